### sv/gtls_pkg.sv
// shared types and constants for the gray texture sampler
`timescale 1ns / 1ps

package gtls_pkg;

   // texture store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;

   // configuration register widths
   localparam int SIZE_W     = 9;
   localparam int TILE_W     = 8;
   localparam int MAXV_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_TILING     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_TILING     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RGB_MODE     = 3'd5;

   // luma and normalization arithmetic
   localparam int SUM_W = 18;
   localparam int NUM_W = SUM_W + 16;
   localparam logic [SUM_W-1:0] LUMA_R_COEF = 18'd299;
   localparam logic [SUM_W-1:0] LUMA_G_COEF = 18'd587;
   localparam logic [SUM_W-1:0] LUMA_B_COEF = 18'd114;
   localparam logic [SUM_W-1:0] LUMA_SCALE  = 18'd1000;

   // shared divider
   localparam int DIV_STEPS = 16;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   // request commands
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_INT    = 2'd1;
   localparam logic [1:0] CMD_UV     = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
      logic [15:0]        u_frac;
      logic [15:0]        v_frac;
   } req_type;

   typedef struct packed {
      logic [15:0] gray_value;
      logic [7:0]  gray_level;
   } rsp_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LUMA,
      OP_LOAD_INIT,
      OP_DIV_STEP,
      OP_LOAD_WRITE,
      OP_WRAP_INIT,
      OP_WRAP_FIX,
      OP_TILE_MUL,
      OP_TILE_INIT,
      OP_UV_MUL1,
      OP_UV_MUL2,
      OP_UV_INIT,
      OP_SET_COORD,
      OP_READ,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   axis;   // 0 column, 1 row
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD_SUM,
      ST_LOAD_INIT,
      ST_LOAD_DIV,
      ST_LOAD_WRITE,
      ST_WRAP_INIT,
      ST_WRAP_DIV,
      ST_WRAP_FIX,
      ST_TILE_MUL,
      ST_TILE_INIT,
      ST_TILE_DIV,
      ST_UV_MUL1,
      ST_UV_MUL2,
      ST_UV_INIT,
      ST_UV_DIV,
      ST_SET_COORD,
      ST_READ,
      ST_RESULT
   } state_type;

endpackage

### sv/gtls_ctrl.sv
// controller state machine sequencing loads and lookups
`timescale 1ns / 1ps

module gtls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_ready,
   output gtls_pkg::dp_cmd_type   dp_cmd,
   input  gtls_pkg::dp_status_type dp_status
);
   import gtls_pkg::*;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;
   logic      uv_ff, uv_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 1'b0;
         uv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         uv_ff    <= uv_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      uv_in       = uv_ff;
      req_ready   = 1'b0;
      dp_cmd.op   = OP_NONE;
      dp_cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            axis_in   = 1'b0;
            if (req_valid) begin
               dp_cmd.op = OP_CAPTURE;
               priority if (req_cmd == CMD_LOAD) begin
                  state_in = ST_LOAD_SUM;
               end else if (req_cmd == CMD_INT) begin
                  uv_in    = 1'b0;
                  state_in = ST_WRAP_INIT;
               end else if (req_cmd == CMD_UV) begin
                  uv_in    = 1'b1;
                  state_in = ST_UV_MUL1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         // load path: luma, normalize, store
         ST_LOAD_SUM: begin
            dp_cmd.op = OP_LUMA;
            state_in  = ST_LOAD_INIT;
         end
         ST_LOAD_INIT: begin
            dp_cmd.op = OP_LOAD_INIT;
            state_in  = ST_LOAD_DIV;
         end
         ST_LOAD_DIV: begin
            dp_cmd.op = OP_DIV_STEP;
            if (dp_status.div_last) state_in = ST_LOAD_WRITE;
         end
         ST_LOAD_WRITE: begin
            dp_cmd.op = OP_LOAD_WRITE;
            state_in  = ST_IDLE;
         end
         // integer lookup: wrap, tile, wrap again
         ST_WRAP_INIT: begin
            dp_cmd.op = OP_WRAP_INIT;
            state_in  = ST_WRAP_DIV;
         end
         ST_WRAP_DIV: begin
            dp_cmd.op = OP_DIV_STEP;
            if (dp_status.div_last) state_in = ST_WRAP_FIX;
         end
         ST_WRAP_FIX: begin
            dp_cmd.op = OP_WRAP_FIX;
            state_in  = ST_TILE_MUL;
         end
         ST_TILE_MUL: begin
            dp_cmd.op = OP_TILE_MUL;
            state_in  = ST_TILE_INIT;
         end
         ST_TILE_INIT: begin
            dp_cmd.op = OP_TILE_INIT;
            state_in  = ST_TILE_DIV;
         end
         ST_TILE_DIV: begin
            dp_cmd.op = OP_DIV_STEP;
            if (dp_status.div_last) state_in = ST_SET_COORD;
         end
         // u,v lookup: scale by size and tiling, wrap
         ST_UV_MUL1: begin
            dp_cmd.op = OP_UV_MUL1;
            state_in  = ST_UV_MUL2;
         end
         ST_UV_MUL2: begin
            dp_cmd.op = OP_UV_MUL2;
            state_in  = ST_UV_INIT;
         end
         ST_UV_INIT: begin
            dp_cmd.op = OP_UV_INIT;
            state_in  = ST_UV_DIV;
         end
         ST_UV_DIV: begin
            dp_cmd.op = OP_DIV_STEP;
            if (dp_status.div_last) state_in = ST_SET_COORD;
         end
         // column done moves on to the row, row done reads the store
         ST_SET_COORD: begin
            dp_cmd.op = OP_SET_COORD;
            if (axis_ff) begin
               state_in = ST_READ;
            end else begin
               axis_in  = 1'b1;
               state_in = uv_ff ? ST_UV_MUL1 : ST_WRAP_INIT;
            end
         end
         ST_READ: begin
            dp_cmd.op = OP_READ;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            if (dp_status.out_free) begin
               dp_cmd.op = OP_RESULT;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/gtls_dpath.sv
// datapath: configuration, shared multiplier and divider, texel store, result register
`timescale 1ns / 1ps

module gtls_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  gtls_pkg::dp_cmd_type              dp_cmd,
   output gtls_pkg::dp_status_type           dp_status,
   input  gtls_pkg::req_type                 req_data,
   input  logic                              csr_we,
   input  logic [gtls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gtls_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gtls_pkg::rsp_type                 rsp_data
);
   import gtls_pkg::*;

   // configuration registers
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [TILE_W-1:0] xtile_ff, ytile_ff;
   logic [MAXV_W-1:0] maxv_ff;
   logic              rgb_ff;

   // working registers
   req_type           req_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  den_ff;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [15:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              sat_ff;
   logic              neg_ff;
   logic [7:0]        wcoord_ff;
   logic [31:0]       prod_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  load_col_ff;
   logic [ROW_W-1:0]  load_row_ff;
   logic [15:0]       rdata_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [15:0] mem [MAX_WIDTH*MAX_HEIGHT];

   logic [SIZE_W-1:0] eff_w, eff_h, size_sel;
   logic [TILE_W-1:0] tile_sel;
   logic [MAXV_W-1:0] maxv_eff;
   logic [15:0]       coord_sel, frac_sel, coord_mag;
   logic [SUM_W-1:0]  luma_sum;
   logic [NUM_W-1:0]  numer;
   logic [SUM_W:0]    trial;
   logic              trial_ge;
   logic [SIZE_W-1:0] wrap_rem, wrap_val;
   logic [SIZE_W-1:0] load_col_cur, load_row_cur, load_col_nxt, load_row_nxt;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;
   logic [24:0]       level_x, level_q;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= MAX_W_SIZE;
         height_ff <= MAX_H_SIZE;
         xtile_ff  <= 8'd1;
         ytile_ff  <= 8'd1;
         maxv_ff   <= 8'd255;
         rgb_ff    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_X_TILING:     xtile_ff  <= csr_wdata[TILE_W-1:0];
            CSR_Y_TILING:     ytile_ff  <= csr_wdata[TILE_W-1:0];
            CSR_MAX_VALUE:    maxv_ff   <= csr_wdata[MAXV_W-1:0];
            CSR_RGB_MODE:     rgb_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective sizes and per-axis selection
   always_comb begin
      eff_w     = (width_ff == '0) ? SIZE_W'(1) :
                  ((width_ff > MAX_W_SIZE) ? MAX_W_SIZE : width_ff);
      eff_h     = (height_ff == '0) ? SIZE_W'(1) :
                  ((height_ff > MAX_H_SIZE) ? MAX_H_SIZE : height_ff);
      maxv_eff  = (maxv_ff == '0) ? MAXV_W'(1) : maxv_ff;
      size_sel  = dp_cmd.axis ? eff_h : eff_w;
      tile_sel  = dp_cmd.axis ? ytile_ff : xtile_ff;
      coord_sel = dp_cmd.axis ? req_ff.y_coord : req_ff.x_coord;
      frac_sel  = dp_cmd.axis ? req_ff.v_frac : req_ff.u_frac;
      coord_mag = coord_sel[15] ? (16'd0 - coord_sel) : coord_sel;
   end

   // luma sum, gray mode scaled to the same units
   always_comb begin
      if (rgb_ff) begin
         luma_sum = SUM_W'(req_ff.red) * LUMA_R_COEF + SUM_W'(req_ff.green) * LUMA_G_COEF
                  + SUM_W'(req_ff.blue) * LUMA_B_COEF;
      end else begin
         luma_sum = SUM_W'(req_ff.red) * LUMA_SCALE;
      end
      numer = {sum_ff, 16'd0} - NUM_W'(sum_ff);
   end

   // one restoring division step
   always_comb begin
      trial    = {rem_ff, quo_ff[15]};
      trial_ge = (trial >= {1'b0, den_ff});
   end

   // wrap fix for negative coordinates
   always_comb begin
      wrap_rem = rem_ff[SIZE_W-1:0];
      wrap_val = (neg_ff && wrap_rem != '0) ? (size_sel - wrap_rem) : wrap_rem;
   end

   // load position, pulled back in range if the size shrank
   always_comb begin
      load_col_cur = (SIZE_W'(load_col_ff) >= eff_w) ? '0 : SIZE_W'(load_col_ff);
      load_row_cur = (SIZE_W'(load_row_ff) >= eff_h) ? '0 : SIZE_W'(load_row_ff);
      load_col_nxt = load_col_cur + SIZE_W'(1);
      load_row_nxt = load_row_cur;
      if (load_col_nxt >= eff_w) begin
         load_col_nxt = '0;
         load_row_nxt = load_row_cur + SIZE_W'(1);
         if (load_row_nxt >= eff_h) load_row_nxt = '0;
      end
      mem_we    = (dp_cmd.op == OP_LOAD_WRITE);
      mem_waddr = {load_row_cur[ROW_W-1:0], load_col_cur[COL_W-1:0]};
      mem_wdata = sat_ff ? 16'hFFFF : quo_ff;
   end

   // divider registers
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      unique case (dp_cmd.op)
         OP_LOAD_INIT: begin
            rem_in = numer[NUM_W-1:16];
            quo_in = numer[15:0];
            cnt_in = CNT_W'(DIV_STEPS);
         end
         OP_WRAP_INIT: begin
            rem_in = '0;
            quo_in = coord_mag;
            cnt_in = CNT_W'(DIV_STEPS);
         end
         OP_TILE_INIT: begin
            rem_in = '0;
            quo_in = prod_ff[15:0];
            cnt_in = CNT_W'(DIV_STEPS);
         end
         OP_UV_INIT: begin
            rem_in = '0;
            quo_in = prod_ff[31:16];
            cnt_in = CNT_W'(DIV_STEPS);
         end
         OP_DIV_STEP: begin
            rem_in = trial_ge ? SUM_W'(trial - {1'b0, den_ff}) : trial[SUM_W-1:0];
            quo_in = {quo_ff[14:0], trial_ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   // operand and result registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      unique case (dp_cmd.op)
         OP_CAPTURE: req_ff <= req_data;
         OP_LUMA: begin
            sum_ff <= luma_sum;
            den_ff <= SUM_W'(maxv_eff) * LUMA_SCALE;
         end
         OP_LOAD_INIT: sat_ff <= (numer >= {den_ff, 16'd0});
         OP_WRAP_INIT: begin
            neg_ff <= coord_sel[15];
            den_ff <= SUM_W'(size_sel);
         end
         OP_WRAP_FIX:  wcoord_ff <= wrap_val[7:0];
         OP_TILE_MUL:  prod_ff <= 32'(wcoord_ff) * 32'(tile_sel);
         OP_UV_MUL1: begin
            prod_ff <= 32'(frac_sel) * 32'(size_sel);
            den_ff  <= SUM_W'(size_sel);
         end
         OP_UV_MUL2:   prod_ff <= 32'(prod_ff[23:0]) * 32'(tile_sel);
         OP_SET_COORD: begin
            if (dp_cmd.axis) row_ff <= rem_ff[ROW_W-1:0];
            else             col_ff <= rem_ff[COL_W-1:0];
         end
         default: ;
      endcase
   end

   // load position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff <= '0;
         load_row_ff <= '0;
      end else if (dp_cmd.op == OP_LOAD_WRITE) begin
         load_col_ff <= load_col_nxt[COL_W-1:0];
         load_row_ff <= load_row_nxt[ROW_W-1:0];
      end
   end

   // texel store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (dp_cmd.op == OP_READ) rdata_ff <= mem[{row_ff, col_ff}];
   end

   // gray level = floor(v * 255 / 65535)
   always_comb begin
      level_x = {1'b0, rdata_ff, 8'd0} - 25'(rdata_ff);
      level_q = level_x + 25'(level_x[24:16]) + 25'd1;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.op == OP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_RESULT) begin
         rsp_ff.gray_value <= rdata_ff;
         rsp_ff.gray_level <= level_q[23:16];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_ff;
   assign dp_status.div_last  = (cnt_ff == CNT_W'(1));
   assign dp_status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

### sv/gray_texture_load_and_tiled_sample.sv
// top level of the gray texture store with tiled nearest sampling
//
//  port group | direction | transfer when      | carries
//  req_*      | in        | req_valid & ready | one load or lookup command
//  rsp_*      | out       | rsp_valid & ready | sampled gray value and level
//  csr_*      | in        | csr_we            | one configuration register write
//
// one command at a time; req_ready is high only while the controller is idle
// load: luma, normalize setup, 16 divider steps, store write
// the 16-step shared divider runs twice per axis for integer lookups and once per axis
// for u,v lookups
// unused command code: no transfer on rsp
// reset is synchronous; the texel store is not cleared, unloaded texels read undefined
// a stalled rsp holds the finished lookup in its final state until the output frees
`timescale 1ns / 1ps

module gray_texture_load_and_tiled_sample (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gtls_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gtls_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [gtls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gtls_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gtls_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // controller
   gtls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // datapath
   gtls_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/gtls_checker.sv
// port-level checks for the gray texture sampler, bound to the top level
`timescale 1ns / 1ps

module gtls_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input gtls_pkg::req_type                 req_data,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input gtls_pkg::rsp_type                 rsp_data
);
   import gtls_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // a real command keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd != CMD_UNUSED |=> !req_ready)
      else $error("req_ready high right after a command transfer");

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // no result appears the cycle after a command is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared right after a command transfer");

endmodule

bind gray_texture_load_and_tiled_sample gtls_checker u_gtls_checker (.*);

### verif/tb.sv
// self-checking testbench for the gray texture store with tiled nearest sampling
`timescale 1ns / 1ps

module tb;
   import gtls_pkg::*;

   localparam int SETTLE_CYCLES   = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS     = 64;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gray_texture_load_and_tiled_sample dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow texture store, load position and register copy
   logic [15:0] texel_shadow [0:MAX_WIDTH*MAX_HEIGHT-1];
   bit          texel_loaded [0:MAX_WIDTH*MAX_HEIGHT-1];
   int unsigned load_col = 0;
   int unsigned load_row = 0;
   int unsigned cfg_width = 256;
   int unsigned cfg_height = 256;
   int unsigned cfg_x_tiling = 1;
   int unsigned cfg_y_tiling = 1;
   int unsigned cfg_max_value = 255;
   int unsigned cfg_rgb_mode = 1;

   // samples still owed by the block, oldest first
   rsp_type     pending_texels [$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        hold_rsp = 1'b0;
   int          error_count = 0;
   int          loads_sent = 0;
   int          lookups_sent = 0;
   int          unused_sent = 0;
   int          results_checked = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // size register as the block uses it
   function automatic int unsigned clamp_size(int unsigned size, int unsigned limit);
      if (size == 0) return 1;
      if (size > limit) return limit;
      return size;
   endfunction

   // signed coordinate folded into 0..size-1
   function automatic int unsigned wrap_coord(logic signed [15:0] coord, int unsigned size);
      int s;
      int m;
      s = coord;
      m = s % int'(size);
      if (m < 0) m += int'(size);
      return m;
   endfunction

   // store address that a lookup selects under the current settings
   function automatic int unsigned texel_addr(req_type item);
      int unsigned w, h, col, row;
      longint unsigned su, sv;
      w = clamp_size(cfg_width, MAX_WIDTH);
      h = clamp_size(cfg_height, MAX_HEIGHT);
      if (item.cmd == CMD_INT) begin
         col = (wrap_coord(item.x_coord, w) * cfg_x_tiling) % w;
         row = (wrap_coord(item.y_coord, h) * cfg_y_tiling) % h;
      end else begin
         su = item.u_frac;
         sv = item.v_frac;
         su = (su * w * cfg_x_tiling) >> 16;
         sv = (sv * h * cfg_y_tiling) >> 16;
         col = su % w;
         row = sv % h;
      end
      return row * MAX_WIDTH + col;
   endfunction

   function automatic req_type random_req(logic [1:0] cmd);
      req_type item;
      item.cmd     = cmd;
      item.red     = 8'($urandom);
      item.green   = 8'($urandom);
      item.blue    = 8'($urandom);
      item.x_coord = 16'($urandom);
      item.y_coord = 16'($urandom);
      item.u_frac  = 16'($urandom);
      item.v_frac  = 16'($urandom);
      return item;
   endfunction

   // one request transfer, then update the shadow and the owed samples
   task automatic send_item(input req_type item);
      int unsigned     addr, w, h;
      longint unsigned r, g, b, mx, q;
      rsp_type         predicted;
      if (item.cmd == CMD_INT || item.cmd == CMD_UV) begin
         addr = texel_addr(item);
         // texels never loaded read back undefined, keep away from them
         if (!texel_loaded[addr]) return;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (item.cmd)
         CMD_LOAD: begin
            w  = clamp_size(cfg_width, MAX_WIDTH);
            h  = clamp_size(cfg_height, MAX_HEIGHT);
            r  = item.red;
            g  = item.green;
            b  = item.blue;
            mx = (cfg_max_value == 0) ? 1 : cfg_max_value;
            // luma weights in thousandths
            if (cfg_rgb_mode != 0) q = 65535 * (299 * r + 587 * g + 114 * b) / (1000 * mx);
            else q = 65535 * r / mx;
            if (q > 65535) q = 65535;
            // a shrunken image pulls an out-of-range load column or row back to zero
            if (load_col >= w) load_col = 0;
            if (load_row >= h) load_row = 0;
            addr = load_row * MAX_WIDTH + load_col;
            texel_shadow[addr] = q[15:0];
            texel_loaded[addr] = 1'b1;
            load_col++;
            if (load_col >= w) begin
               load_col = 0;
               load_row++;
               if (load_row >= h) load_row = 0;
            end
            loads_sent++;
         end
         CMD_INT, CMD_UV: begin
            q = texel_shadow[addr];
            predicted.gray_value = texel_shadow[addr];
            q = (q * 255) / 65535;
            predicted.gray_level = q[7:0];
            pending_texels.push_back(predicted);
            lookups_sent++;
         end
         default: unused_sent++;
      endcase
   endtask

   task automatic send_load(input logic [7:0] r, g, b);
      req_type item;
      item       = random_req(CMD_LOAD);
      item.red   = r;
      item.green = g;
      item.blue  = b;
      send_item(item);
   endtask

   task automatic send_int(input logic signed [15:0] x, y);
      req_type item;
      item         = random_req(CMD_INT);
      item.x_coord = x;
      item.y_coord = y;
      send_item(item);
   endtask

   task automatic send_uv(input logic [15:0] u, v);
      req_type item;
      item        = random_req(CMD_UV);
      item.u_frac = u;
      item.v_frac = v;
      send_item(item);
   endtask

   // random lookup that lands on a loaded texel
   task automatic send_random_lookup();
      req_type     item;
      int unsigned w, h;
      w = clamp_size(cfg_width, MAX_WIDTH);
      h = clamp_size(cfg_height, MAX_HEIGHT);
      for (int tries = 0; tries < 16; tries++) begin
         item = random_req($urandom_range(1) ? CMD_UV : CMD_INT);
         if (item.cmd == CMD_INT && $urandom_range(1) == 1) begin
            // a few wraps either side of the image
            item.x_coord = 16'($urandom_range(6 * w) - 3 * w);
            item.y_coord = 16'($urandom_range(6 * h) - 3 * h);
         end
         if (texel_loaded[texel_addr(item)]) break;
         // corner texel has been loaded since the first test
         if (tries == 15) begin
            item         = random_req(CMD_INT);
            item.x_coord = '0;
            item.y_coord = '0;
         end
      end
      send_item(item);
   endtask

   // load a whole small image, or a stretch of a large one
   task automatic fill_image();
      int unsigned count;
      count = clamp_size(cfg_width, MAX_WIDTH) * clamp_size(cfg_height, MAX_HEIGHT);
      if (count > 300) count = 64;
      repeat (count) send_load(8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // write every register once the block has gone idle
   task automatic set_config(input logic [CSR_DATA_W-1:0] w, h, xt, yt, mx, rgb);
      logic [CSR_IDX_W-1:0]  reg_index [6];
      logic [CSR_DATA_W-1:0] reg_value [6];
      reg_index[0] = CSR_IMAGE_WIDTH;  reg_value[0] = w;
      reg_index[1] = CSR_IMAGE_HEIGHT; reg_value[1] = h;
      reg_index[2] = CSR_X_TILING;     reg_value[2] = xt & 9'h0FF;
      reg_index[3] = CSR_Y_TILING;     reg_value[3] = yt & 9'h0FF;
      reg_index[4] = CSR_MAX_VALUE;    reg_value[4] = mx & 9'h0FF;
      reg_index[5] = CSR_RGB_MODE;     reg_value[5] = rgb & 9'h001;
      req_valid <= 1'b0;
      while (pending_texels.size() != 0) @(posedge clock);
      // loads give no result, so allow the longest command to finish
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_index[i];
         csr_wdata <= reg_value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_width     = reg_value[0];
      cfg_height    = reg_value[1];
      cfg_x_tiling  = reg_value[2];
      cfg_y_tiling  = reg_value[3];
      cfg_max_value = reg_value[4];
      cfg_rgb_mode  = reg_value[5];
   endtask

   // gray loads into a 2x2 image, wrap of the load order, lookups at the extremes
   task automatic test_gray_loads_and_lookups();
      set_config(2, 2, 1, 1, 255, 0);
      send_load(8'd0, 8'hFF, 8'hFF);
      send_load(8'hFF, 8'd0, 8'd0);
      send_load(8'd7, 8'h55, 8'hAA);
      send_load(8'd128, 8'hAA, 8'h55);
      // fifth load overwrites the first texel
      send_load(8'd200, 8'd0, 8'd0);
      send_int(16'sd0, 16'sd0);
      send_int(16'sd1, 16'sd0);
      send_int(-16'sd1, -16'sd1);
      send_int(16'h7FFF, 16'h8000);
      send_uv(16'd0, 16'd0);
      send_uv(16'hFFFF, 16'hFFFF);
      send_item(random_req(CMD_UNUSED));
   endtask

   // zero width and maximum, rgb saturation, zero tiling
   task automatic test_rgb_saturation_small_image();
      set_config(0, 1, 0, 0, 0, 1);
      send_load(8'hFF, 8'hFF, 8'hFF);
      send_load(8'd0, 8'd0, 8'd0);
      send_load(8'd1, 8'd0, 8'd0);
      send_int(16'sd5, -16'sd3);
      send_uv(16'hFFFF, 16'd1234);
   endtask

   // sizes above the store limits act as the limits, tiling at its top
   task automatic test_oversized_image();
      set_config(300, 511, 255, 255, 255, 1);
      send_load(8'hFF, 8'hFF, 8'hFF);
      send_load(8'd0, 8'hFF, 8'd0);
      send_load(8'd0, 8'd0, 8'hFF);
      send_int(16'sd0, 16'sd0);
      send_int(16'h7FFF, 16'h8000);
      send_uv(16'd258, 16'd1);
   endtask

   // output held off while lookups keep coming, block must stall its input
   task automatic test_rsp_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_config(4, 4, 3, 2, 200, 0);
      fill_image();
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      repeat (12) send_random_lookup();
   endtask

   // random traffic over several settings and idling mixes
   task automatic test_random_traffic();
      int unsigned tx_pct [4];
      int unsigned rx_pct [4];
      int unsigned w, h, xt, yt;
      int          pick;
      tx_pct = '{0, 53, 0, 20};
      rx_pct = '{0, 0, 53, 20};
      for (int p = 0; p < 8; p++) begin
         send_idle_pct = tx_pct[p % 4];
         rsp_stall_pct = rx_pct[p % 4];
         case (p)
            0: set_config(8, 6, 1, 1, 255, 1);
            1: set_config(16, 16, 3, 5, 100, 0);
            2: set_config(1, 16, 255, 0, 37, 1);
            3: set_config(256, 256, 2, 7, 255, 0);
            default: begin
               w = $urandom_range(17);
               if (w == 17) w = $urandom_range(511, 257);
               h = $urandom_range(17);
               if (h == 17) h = $urandom_range(511, 257);
               xt = ($urandom_range(3) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
               yt = ($urandom_range(3) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
               set_config(9'(w), 9'(h), 9'(xt), 9'(yt),
                          9'($urandom_range(255)), 9'($urandom_range(1)));
            end
         endcase
         fill_image();
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 30) send_load(8'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 95) send_random_lookup();
            else send_item(random_req(CMD_UNUSED));
         end
      end
   endtask

   // output side stalls at random, or holds off entirely
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
   end

   // compare each result transfer with the oldest owed sample
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_texels.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result: value %h level %h",
                        rsp_data.gray_value, rsp_data.gray_level);
            error_count++;
         end else begin
            want = pending_texels.pop_front();
            results_checked++;
            if (rsp_data.gray_value !== want.gray_value ||
                rsp_data.gray_level !== want.gray_level) begin
               if (error_count < 10)
                  $display("mismatch: expected value %h level %h, got value %h level %h",
                           want.gray_value, want.gray_level,
                           rsp_data.gray_value, rsp_data.gray_level);
               error_count++;
            end
         end
      end
   end

   // test sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_gray_loads_and_lookups();
      test_rgb_saturation_small_image();
      test_oversized_image();
      test_rsp_hold_off();
      test_random_traffic();
      req_valid <= 1'b0;
      for (int n = 0; n < 20000 && pending_texels.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_texels.size() != 0) begin
         $display("%0d results never arrived", pending_texels.size());
         error_count += pending_texels.size();
      end
      $display("summary: %0d loads, %0d lookups, %0d unused commands, %0d results checked",
               loads_sent, lookups_sent, unused_sent, results_checked);
      $display("summary: gray and rgb loads, clamped sizes and maxima, tiling 0 to 255, %s",
               "mixed idling and a long output hold-off");
      if (error_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", pending_texels.size());
      $display("tb: FAIL");
      $finish;
   end

endmodule
